@@ rtl/mf3_pkg.sv @@
// shared constants and register codes for the 3x3 median filter
`timescale 1ns / 1ps
`default_nettype none

package mf3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;

  localparam int TAPS = 3;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

endpackage

`default_nettype wire

@@ rtl/mf3_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module mf3_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/mf3_median9.sv @@
// median of nine from three presorted columns
`timescale 1ns / 1ps
`default_nettype none

module mf3_median9
  import mf3_pkg::*;
#(
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic [PIXEL_BITS-1:0] col_lo  [TAPS],
  input  wire logic [PIXEL_BITS-1:0] col_mid [TAPS],
  input  wire logic [PIXEL_BITS-1:0] col_hi  [TAPS],
  output logic      [PIXEL_BITS-1:0] med
);

  function automatic logic [PIXEL_BITS-1:0] min2(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] max2(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [PIXEL_BITS-1:0] med3(input logic [PIXEL_BITS-1:0] a,
                                                 input logic [PIXEL_BITS-1:0] b,
                                                 input logic [PIXEL_BITS-1:0] c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  logic [PIXEL_BITS-1:0] max_lo;
  logic [PIXEL_BITS-1:0] med_mid;
  logic [PIXEL_BITS-1:0] min_hi;

  always_comb begin
    max_lo  = max2(max2(col_lo[0], col_lo[1]), col_lo[2]);
    med_mid = med3(col_mid[0], col_mid[1], col_mid[2]);
    min_hi  = min2(min2(col_hi[0], col_hi[1]), col_hi[2]);
    med     = med3(max_lo, med_mid, min_hi);
  end

endmodule

`default_nettype wire

@@ rtl/median_filter_3x3.sv @@
// 3x3 median filter over a raster pixel stream, top level
// throughput: one word per cycle, pixel or drain, unless out_ready holds the output back
// each result passes the ram stage and the window before the output register
// the row store is one ram read per word; a read-after-write bypass covers narrow frames
// each result trails its input pixel by eff_w+1 words in the stream
// reset (rst_n low, synchronous) clears counters, valids, window and sets size to 1024x1024
`timescale 1ns / 1ps
`default_nettype none

module median_filter_3x3
  import mf3_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,

  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_opcode,
  input  wire logic [PIXEL_BITS-1:0]  in_pixel_in,

  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic      [PIXEL_BITS-1:0]  out_pixel_out,
  output logic                        out_frame_end
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WCNT_W = COL_W + 1;
  localparam int OROW_W = HEIGHT_REG_W;
  localparam int IROW_W = HEIGHT_REG_W + 1;
  localparam int PAIR_W = 2 * PIXEL_BITS;

  // configuration
  logic [WIDTH_REG_W-1:0]  image_width_r;
  logic [HEIGHT_REG_W-1:0] image_height_r;
  logic [WCNT_W-1:0]       eff_w;
  logic [HEIGHT_REG_W-1:0] eff_h;

  // position counters
  logic [COL_W-1:0]  in_col_r,  in_col_nxt;
  logic [IROW_W-1:0] in_row_r,  in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;

  logic                  draining;
  logic                  accept;
  logic                  take;
  logic [PIXEL_BITS-1:0] pix0;
  logic                  emit0;
  logic                  interior0;
  logic                  last0;
  logic [WCNT_W-1:0]     icol_p1;
  logic [WCNT_W-1:0]     ocol_p1;
  logic [IROW_W-1:0]     orow_p1;

  // stage 1: ram read data
  logic                  v1_r;
  logic [COL_W-1:0]      addr1_r;
  logic [PIXEL_BITS-1:0] pix1_r;
  logic                  emit1_r;
  logic                  interior1_r;
  logic                  last1_r;
  logic                  byp_r;
  logic                  byp_nxt;
  logic [PAIR_W-1:0]     bypd_r;
  logic [PAIR_W-1:0]     ram_rdata;
  logic [PAIR_W-1:0]     pair1;
  logic [PIXEL_BITS-1:0] up1, lo1;
  logic [PIXEL_BITS-1:0] s_a, s_b, s_t;
  logic [PIXEL_BITS-1:0] c_lo, c_md, c_hi;
  logic                  mv1;

  // stage 2: window
  logic                  v2_r;
  logic                  interior2_r;
  logic                  last2_r;
  logic [PIXEL_BITS-1:0] lo_r  [TAPS];
  logic [PIXEL_BITS-1:0] md_r  [TAPS];
  logic [PIXEL_BITS-1:0] hi_r  [TAPS];
  logic [PIXEL_BITS-1:0] mid4_r, mid5_r;
  logic [PIXEL_BITS-1:0] med;
  logic                  mv2;

  // output register
  logic                  out_valid_r;
  logic [PIXEL_BITS-1:0] out_pix_r;
  logic                  out_end_r;

  // effective frame size
  always_comb begin
    if (image_width_r == '0) begin
      eff_w = WCNT_W'(1);
    end else if (int'(image_width_r) > MAX_WIDTH) begin
      eff_w = WCNT_W'(MAX_WIDTH);
    end else begin
      eff_w = WCNT_W'(image_width_r);
    end
    eff_h = (image_height_r == '0) ? HEIGHT_REG_W'(1) : image_height_r;
  end

  // handshake across the stages
  assign mv2      = v2_r && (!out_valid_r || out_ready);
  assign mv1      = v1_r && (!v2_r || mv2);
  assign in_ready = !v1_r || mv1;

  // input and output position logic
  always_comb begin
    draining  = in_row_r >= IROW_W'(eff_h);
    accept    = in_valid && in_ready;
    take      = accept && !((in_opcode == OP_DRAIN) && !draining);
    pix0      = draining ? '0 : in_pixel_in;
    icol_p1   = WCNT_W'(in_col_r) + WCNT_W'(1);
    ocol_p1   = WCNT_W'(out_col_r) + WCNT_W'(1);
    orow_p1   = IROW_W'(out_row_r) + IROW_W'(1);
    emit0     = (in_row_r >= IROW_W'(2)) || ((in_row_r == IROW_W'(1)) && (in_col_r != '0));
    interior0 = (out_row_r != '0) && (orow_p1 < IROW_W'(eff_h)) &&
                (out_col_r != '0) && (ocol_p1 < eff_w);
    last0     = (orow_p1 >= IROW_W'(eff_h)) && (ocol_p1 >= eff_w);

    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (take) begin
      if (icol_p1 >= eff_w) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + IROW_W'(1);
      end else begin
        in_col_nxt = COL_W'(icol_p1);
      end
      if (emit0) begin
        if (last0) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (ocol_p1 >= eff_w) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OROW_W'(1);
        end else begin
          out_col_nxt = COL_W'(ocol_p1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
      in_col_r       <= '0;
      in_row_r       <= '0;
      out_col_r      <= '0;
      out_row_r      <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // row stores, upper row in the high half
  mf3_ram #(
    .DATA_W (PAIR_W),
    .DEPTH  (MAX_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (mv1),
    .waddr (addr1_r),
    .wdata ({lo1, pix1_r}),
    .re    (take),
    .raddr (in_col_r),
    .rdata (ram_rdata)
  );

  // previous word writes the address read now
  assign byp_nxt = take && mv1 && (in_col_r == addr1_r);

  always_comb begin
    pair1 = byp_r ? bypd_r : ram_rdata;
    up1   = pair1[PAIR_W-1:PIXEL_BITS];
    lo1   = pair1[PIXEL_BITS-1:0];
    // sort the new column
    s_a   = (up1 < lo1) ? up1 : lo1;
    s_b   = (up1 < lo1) ? lo1 : up1;
    c_lo  = (s_a < pix1_r) ? s_a : pix1_r;
    s_t   = (s_a < pix1_r) ? pix1_r : s_a;
    c_md  = (s_b < s_t) ? s_b : s_t;
    c_hi  = (s_b < s_t) ? s_t : s_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      byp_r <= 1'b0;
    end else if (in_ready) begin
      v1_r  <= take;
      byp_r <= byp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr1_r     <= in_col_r;
      pix1_r      <= pix0;
      emit1_r     <= emit0;
      interior1_r <= interior0;
      last1_r     <= last0;
      bypd_r      <= {lo1, pix1_r};
    end
  end

  // window shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        lo_r[i] <= '0;
        md_r[i] <= '0;
        hi_r[i] <= '0;
      end
      mid4_r <= '0;
      mid5_r <= '0;
    end else if (mv1) begin
      v2_r <= emit1_r;
      for (int i = 0; i < TAPS - 1; i++) begin
        lo_r[i] <= lo_r[i+1];
        md_r[i] <= md_r[i+1];
        hi_r[i] <= hi_r[i+1];
      end
      lo_r[TAPS-1] <= c_lo;
      md_r[TAPS-1] <= c_md;
      hi_r[TAPS-1] <= c_hi;
      mid4_r       <= mid5_r;
      mid5_r       <= lo1;
    end else if (mv2) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      interior2_r <= interior1_r;
      last2_r     <= last1_r;
    end
  end

  mf3_median9 #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_med (
    .col_lo  (lo_r),
    .col_mid (md_r),
    .col_hi  (hi_r),
    .med     (med)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (mv2) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv2) begin
      out_pix_r <= interior2_r ? med : mid4_r;
      out_end_r <= last2_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pix_r;
  assign out_frame_end = out_end_r;

  assert property (@(posedge clk) disable iff (!rst_n) byp_r |-> v1_r)
    else $error("bypass flagged with empty ram stage");

  assert property (@(posedge clk) disable iff (!rst_n) WCNT_W'(in_col_r) < eff_w)
    else $error("input column beyond frame width");

  assert property (@(posedge clk) disable iff (!rst_n) out_row_r < eff_h)
    else $error("output row beyond frame height");

  assert property (@(posedge clk) disable iff (!rst_n)
    take && emit0 && last0 |=> in_col_r == '0 && in_row_r == '0 &&
                               out_col_r == '0 && out_row_r == '0)
    else $error("frame did not restart after last word");

  assert property (@(posedge clk) disable iff (!rst_n)
    accept && !take && !cfg_we |=> $stable(in_col_r) && $stable(in_row_r) &&
                                  $stable(out_col_r) && $stable(out_row_r))
    else $error("dropped drain word moved the counters");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// self-checking testbench for the 3x3 median filter: directed and random frames against a built-in predictor
`timescale 1ns / 1ps

module testbench;
  import mf3_pkg::*;

  localparam int PW = DEF_PIXEL_BITS;
  localparam int ROW_LEN = DEF_MAX_WIDTH;
  localparam int RAND_WORDS = 100;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic          op;
    logic [PW-1:0] pix;
  } stream_word_t;

  typedef struct packed {
    logic [PW-1:0] pix;
    logic          last;
  } filtered_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   in_opcode = OP_PIXEL;
  logic [PW-1:0]          in_pixel_in = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [PW-1:0]          out_pixel_out;
  logic                   out_frame_end;

  median_filter_3x3 DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_pixel_in   (in_pixel_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pixel_out (out_pixel_out),
    .out_frame_end (out_frame_end)
  );

  stream_word_t tx_words[$];
  filtered_t    filtered_q[$];
  int           queued_total = 0;
  int           accepted_total = 0;
  int           counted_words = 0;
  int           errors = 0;
  int           cycle_cnt = 0;
  int           sender_idle = 0;
  int           rx_stall = 0;
  int           hold_req = 0;
  int           hold_len = 0;

  // predictor state
  logic [PW-1:0]           upper_row [ROW_LEN];
  logic [PW-1:0]           lower_row [ROW_LEN];
  logic [PW-1:0]           win [9];
  int unsigned             in_col, in_rw, out_col, out_rw;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_w();
    if (width_reg == 0) return 1;
    if (width_reg > ROW_LEN) return ROW_LEN;
    return width_reg;
  endfunction

  function automatic int unsigned eff_h();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void restart_counts();
    in_col = 0;
    in_rw = 0;
    out_col = 0;
    out_rw = 0;
  endfunction

  function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] d);
    if (idx == REG_IMAGE_WIDTH) begin
      width_reg = d[WIDTH_REG_W-1:0];
    end else begin
      height_reg = d[HEIGHT_REG_W-1:0];
    end
    restart_counts();
  endfunction

  function automatic logic [PW-1:0] window_median();
    logic [PW-1:0] v [9];
    logic [PW-1:0] key;
    int i, j;
    for (i = 0; i < 9; i++) v[i] = win[i];
    for (i = 1; i < 9; i++) begin
      key = v[i];
      j = i - 1;
      while (j >= 0 && v[j] > key) begin
        v[j + 1] = v[j];
        j--;
      end
      v[j + 1] = key;
    end
    return v[4];
  endfunction

  function automatic void filter_step(input logic op, input logic [PW-1:0] pix_in);
    int unsigned w, h, c;
    int k;
    logic [PW-1:0] pix;
    logic [PW-1:0] col [3];
    bit flushing, emit, interior, last_px;
    filtered_t res;
    w = eff_w();
    h = eff_h();
    flushing = (in_rw >= h);
    if (!flushing && op == OP_DRAIN) return;
    pix = flushing ? '0 : pix_in;
    c = (in_col >= w) ? w - 1 : in_col;
    col[0] = upper_row[c];
    col[1] = lower_row[c];
    col[2] = pix;
    upper_row[c] = col[1];
    lower_row[c] = pix;
    for (k = 0; k < 3; k++) begin
      win[k * 3] = win[k * 3 + 1];
      win[k * 3 + 1] = win[k * 3 + 2];
      win[k * 3 + 2] = col[k];
    end
    emit = (in_rw >= 2) || (in_rw == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_rw++;
    end
    if (!emit) return;
    interior = out_rw >= 1 && out_rw + 1 < h && out_col >= 1 && out_col + 1 < w;
    last_px = out_rw + 1 >= h && out_col + 1 >= w;
    res.pix = interior ? window_median() : win[4];
    res.last = last_px;
    filtered_q.push_back(res);
    if (last_px) begin
      restart_counts();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_rw++;
      end
    end
  endfunction

  // driver
  always @(posedge clk) begin : drive_proc
    stream_word_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        filter_step(in_opcode, in_pixel_in);
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (tx_words.size() != 0 && $urandom_range(99) >= sender_idle) begin
          nxt = tx_words.pop_front();
          in_valid <= 1'b1;
          in_opcode <= nxt.op;
          in_pixel_in <= nxt.pix;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor_proc
    int hold_left;
    int hold_seen;
    filtered_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (filtered_q.size() == 0) begin
          $error("unexpected word: pixel_out %0d frame_end %0d", out_pixel_out, out_frame_end);
          errors++;
        end else begin
          want = filtered_q.pop_front();
          if (out_pixel_out !== want.pix) begin
            $error("pixel_out: expected %0d, actual %0d", want.pix, out_pixel_out);
            errors++;
          end
          if (out_frame_end !== want.last) begin
            $error("frame_end: expected %0d, actual %0d", want.last, out_frame_end);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = hold_len;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_word(input logic op, input logic [PW-1:0] pix, input bit counted);
    stream_word_t wd;
    wd.op = op;
    wd.pix = pix;
    tx_words.push_back(wd);
    queued_total++;
    if (counted) counted_words++;
  endtask

  function automatic logic [PW-1:0] pick_pixel(input int mode);
    case (mode)
      1: return $urandom_range(1) ? '1 : '0;
      2: return PW'(100 + $urandom_range(2));
      default: return PW'($urandom_range(255));
    endcase
  endfunction

  task automatic wait_results();
    while (accepted_total != queued_total || filtered_q.size() != 0) @(posedge clk);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input int m);
    case (m % 4)
      0: begin sender_idle = 0;  rx_stall = 0;  end
      1: begin sender_idle = 62; rx_stall = 0;  end
      2: begin sender_idle = 0;  rx_stall = 62; end
      default: begin sender_idle = 10; rx_stall = 10; end
    endcase
  endtask

  task automatic hold_rx(input int len);
    hold_len <= len;
    hold_req <= hold_req + 1;
  endtask

  task automatic set_size(input bit wr_w, input int wv, input bit wr_h, input int hv);
    logic [CFG_DATA_W-1:0] d;
    if (wr_w) begin
      // bits above the width register are dropped by the block
      d = CFG_DATA_W'(wv + $urandom_range(3) * 2048);
      cfg_we <= 1'b1;
      cfg_index <= REG_IMAGE_WIDTH;
      cfg_data <= d;
      @(posedge clk);
      apply_reg(REG_IMAGE_WIDTH, d);
    end
    if (wr_h) begin
      d = CFG_DATA_W'(hv);
      cfg_we <= 1'b1;
      cfg_index <= REG_IMAGE_HEIGHT;
      cfg_data <= d;
      @(posedge clk);
      apply_reg(REG_IMAGE_HEIGHT, d);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic push_frame(input int noise_pct, input int val_mode, input bit pause_mid);
    int unsigned w, h, n, k;
    w = eff_w();
    h = eff_h();
    n = w * h;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(99) < noise_pct) push_word(OP_DRAIN, pick_pixel(0), 0);
      if (pause_mid && k == n / 2) wait_results();
      push_word(OP_PIXEL, pick_pixel(val_mode), 1);
    end
    // flush words, pixel words past the frame end act as drains
    for (k = 0; k <= w; k++) begin
      push_word($urandom_range(1) ? OP_DRAIN : OP_PIXEL, pick_pixel(0), 1);
    end
  endtask

  initial begin : main_proc
    logic [PW-1:0] pat [9];
    int i, phase, nf, wv, hv, r;
    for (i = 0; i < ROW_LEN; i++) begin
      upper_row[i] = '0;
      lower_row[i] = '0;
    end
    for (i = 0; i < 9; i++) win[i] = '0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    restart_counts();
    pat = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size, partial frame cut off by a register write
    set_mode(0);
    repeat (40) push_word(OP_PIXEL, pick_pixel(0), 0);
    wait_idle();

    // directed 3x3 frame with an ignored drain, then a tie-heavy frame
    set_size(1, 3, 1, 3);
    for (i = 0; i < 9; i++) begin
      push_word(OP_PIXEL, pat[i], 0);
      if (i == 3) push_word(OP_DRAIN, 8'd77, 0);
    end
    push_word(OP_DRAIN, 8'd0, 0);
    push_word(OP_PIXEL, 8'd255, 0);
    push_word(OP_DRAIN, 8'd255, 0);
    push_word(OP_PIXEL, 8'd0, 0);
    push_frame(0, 2, 1);
    wait_idle();

    // zero width and height act as one
    set_mode(3);
    set_size(1, 0, 1, 0);
    push_frame(0, 1, 0);
    wait_idle();

    // size extremes
    set_mode(1);
    set_size(1, 1, 1, 40);
    push_frame(2, 0, 0);
    wait_idle();

    set_mode(0);
    set_size(1, 30, 1, 3);
    hold_rx(400);
    push_frame(0, 0, 0);
    wait_idle();

    set_mode(2);
    set_size(1, 2047, 1, 8191);
    repeat (1040) push_word(OP_PIXEL, pick_pixel(0), 0);
    wait_idle();

    // random frames
    counted_words = 0;
    phase = 0;
    while (counted_words < RAND_WORDS) begin
      wait_idle();
      set_mode(phase);
      phase++;
      if ($urandom_range(5) == 0) hold_rx($urandom_range(300, 50));
      r = $urandom_range(19);
      if (r < 2) begin
        wv = 0;
        hv = $urandom_range(8, 0);
      end else if (r < 4) begin
        wv = $urandom_range(40, 13);
        hv = $urandom_range(4, 1);
      end else begin
        wv = $urandom_range(12, 1);
        hv = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 0);
      end
      case ($urandom_range(9))
        7: set_size(1, wv, 0, 0);
        8: set_size(0, 0, 1, hv);
        9: ;
        default: set_size(1, wv, 1, hv);
      endcase
      nf = $urandom_range(3, 1);
      for (i = 0; i < nf; i++) begin
        push_frame($urandom_range(1) * 8, $urandom_range(2), $urandom_range(7) == 0);
      end
      // broken frame, cut short when the next round writes a size register
      if ($urandom_range(5) == 0) begin
        repeat ($urandom_range(eff_w() * eff_h(), 1)) push_word(OP_PIXEL, pick_pixel(0), 1);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mf3_pkg.sv
rtl/mf3_ram.sv
rtl/mf3_median9.sv
rtl/median_filter_3x3.sv
verif/testbench.sv
